@@ sv/drl_pkg.sv @@
// Shared widths and defaults for the dense rank lookup block.
package drl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int SCORE_W             = 31;
  localparam int RANK_W              = 11;
  localparam int S_TDATA_W           = 32;  // restart + score, padded to bytes
  localparam int M_TDATA_W           = 16;  // rank + error, padded to bytes

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

@@ sv/drl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module drl_ram
  import drl_pkg::*;
#(
  parameter int WIDTH = SCORE_W,
  parameter int DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/dense_rank_lookup_unit.sv @@
// Dense rank lookup: leaderboard table load and binary-search rank query.
// Load beat: taken while idle; the next beat can follow at once.
// Query beat: each halving step is a RAM read (ISSUE), then a compare (CMP); once the window
//   closes, the result is registered and the block returns to idle for the next beat;
//   a held result stalls the input.
// Reset (rst, sync, active high) empties table and clears error; RAM keeps contents.
module dense_rank_lookup_unit
  import drl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // input beat
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [0] restart, [31:1] score_value
  input  logic                 s_tuser,   // [0] kind: 0 load, 1 query
  // result beat
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // [10:0] dense_rank, [11] load_error, rest 0
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;

  logic [1:0]         state;
  logic [CW-1:0]      entry_count;
  logic               error_flag;
  logic [SCORE_W-1:0] last_score;   // mirror of the table's last entry
  logic [SCORE_W-1:0] query;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [AW-1:0]      mid;

  // input beat fields
  logic               in_restart;
  logic [SCORE_W-1:0] in_score;
  logic               accept;

  assign in_restart = s_tdata[0];
  assign in_score   = s_tdata[SCORE_W:1];
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;

  // load decision: restart applies before the score is checked
  logic [CW-1:0] cnt_eff;
  logic          err_eff;
  logic          ld_dup;
  logic          ld_rise;
  logic          ld_full;
  logic          ld_store;

  always_comb begin
    cnt_eff  = in_restart ? '0 : entry_count;
    err_eff  = in_restart ? 1'b0 : error_flag;
    ld_dup   = (cnt_eff != '0) && (in_score == last_score);
    ld_rise  = (cnt_eff != '0) && (in_score > last_score);
    ld_full  = (cnt_eff >= CW'(TABLE_DEPTH));
    ld_store = !ld_dup && !ld_rise && !ld_full;
  end

  logic ram_we;
  assign ram_we = accept && (s_tuser == KIND_LOAD) && ld_store;

  // search step: split [lo, hi) at its midpoint
  logic [CW-1:0] mid_full;
  logic          searching;
  logic          ram_re;
  logic [SCORE_W-1:0] ram_rdata;

  assign mid_full  = lo + ((hi - lo) >> 1);
  assign searching = (lo < hi);
  assign ram_re    = (state == S_ISSUE) && searching;

  drl_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_eff[AW-1:0]),
    .wdata (in_score),
    .re    (ram_re),
    .raddr (mid_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // rank = count above + 1, wrapped to the field width
  logic [CW:0]       rank_sum;
  logic [RANK_W-1:0] rank;
  logic              out_free;
  logic              post;

  assign rank_sum = {1'b0, lo} + (CW+1)'(1);
  assign rank     = RANK_W'(rank_sum);
  assign out_free = !m_tvalid || m_tready;
  // search closed and the output register can take the result
  assign post     = (state == S_ISSUE) && !searching && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      error_flag  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (post) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == KIND_LOAD) begin
              // drop duplicates silently; flag rising or overflowing loads
              entry_count <= ld_store ? cnt_eff + CW'(1) : cnt_eff;
              error_flag  <= err_eff || ld_rise || (ld_full && !ld_dup && !ld_rise);
              if (ld_store) begin
                last_score <= in_score;
              end
            end else begin
              query <= in_score;
              lo    <= '0;
              hi    <= entry_count;
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (searching) begin
            mid   <= mid_full[AW-1:0];
            state <= S_CMP;
          end else if (post) begin
            // search closed: post the result, hold if the output still waits
            m_tdata  <= M_TDATA_W'({error_flag, rank});
            state    <= S_IDLE;
          end
        end
        S_CMP: begin
          // entries above the query push the lower bound past mid
          if (ram_rdata > query) begin
            lo <= CW'(mid) + CW'(1);
          end else begin
            hi <= CW'(mid);
          end
          state <= S_ISSUE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // a compare step only follows a read inside the open search window
  a_mid_window: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> (CW'(mid) >= lo) && (CW'(mid) < hi))
    else $error("search midpoint outside window");

  // search bounds never exceed the stored count
  a_hi_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE || state == S_CMP) |-> (lo <= hi) && (hi <= entry_count))
    else $error("search bounds out of range");

  // a new result beat only comes from a finished search
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_ISSUE)
    else $error("result posted outside search completion");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the dense rank lookup unit: load and query beats.
module tb_top;
  import drl_pkg::*;

  localparam int BOARD_DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
  localparam int HOLD_START  = 800;    // receiver hold-off window
  localparam int HOLD_LEN    = 400;
  localparam int QUIET_START = 200;    // window with no idling on either side
  localparam int QUIET_END   = 700;
  localparam int TAIL_CYCLES = 40;     // idle tail after the last rank returns
  localparam int RANDOM_BEATS = 100;

  typedef struct packed {
    logic               kind;
    logic               restart;
    logic [SCORE_W-1:0] score;
  } score_beat_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              err;
  } rank_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = KIND_LOAD;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  dense_rank_lookup_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // Beats still to send, and ranks still owed by the block.
  score_beat_t  score_beats[$];
  rank_result_t rank_expect[$];
  int unsigned  beats_total;
  int unsigned  beats_taken;
  int unsigned  mismatches;

  // Predicted leaderboard: distinct scores, strictly falling.
  logic [SCORE_W-1:0] board[BOARD_DEPTH];
  int unsigned        board_count;
  logic               board_err;

  // Generator-side view of the board, used only to shape stimulus.
  logic [SCORE_W-1:0] gen_scores[$];

  // Rank = 1 + number of stored scores strictly above the query.
  function automatic logic [RANK_W-1:0] board_rank(logic [SCORE_W-1:0] q);
    int unsigned above;
    above = 0;
    for (int i = 0; i < board_count; i++) begin
      if (board[i] > q) above++;
    end
    return RANK_W'(above + 1);
  endfunction

  function automatic void board_load(logic restart, logic [SCORE_W-1:0] v);
    if (restart) begin
      board_count = 0;
      board_err   = 1'b0;
    end
    if (board_count > 0) begin
      if (v == board[board_count-1]) return;  // duplicate: absorb
      if (v > board[board_count-1]) begin     // rising: drop
        board_err = 1'b1;
        return;
      end
    end
    if (board_count >= BOARD_DEPTH) begin     // full: drop
      board_err = 1'b1;
      return;
    end
    board[board_count] = v;
    board_count++;
  endfunction

  task automatic push_load(logic restart, logic [SCORE_W-1:0] v);
    score_beat_t beat;
    beat = '{kind: KIND_LOAD, restart: restart, score: v};
    score_beats.insert(score_beats.size(), beat);
    beats_total++;
    if (restart) gen_scores.delete();
    if (gen_scores.size() == 0 || v < gen_scores[$])
      gen_scores.insert(gen_scores.size(), v);
  endtask

  task automatic push_query(logic restart, logic [SCORE_W-1:0] v);
    score_beat_t beat;
    beat = '{kind: KIND_QUERY, restart: restart, score: v};
    score_beats.insert(score_beats.size(), beat);
    beats_total++;
  endtask

  // Next load: mostly falling, some duplicates, a few rising or wild values.
  function automatic logic [SCORE_W-1:0] next_load_score();
    logic [SCORE_W-1:0] last;
    logic [SCORE_W-1:0] step;
    int unsigned        pick;
    if (gen_scores.size() == 0) return SCORE_W'($urandom());
    last = gen_scores[$];
    pick = $urandom_range(99);
    if (pick < 80) begin
      step = SCORE_W'(($urandom() & ((32'd1 << $urandom_range(30)) - 1)) + 1);
      if (last == 0) return '0;
      if (step > last) return SCORE_W'($urandom_range(last - 1));
      return last - step;
    end
    if (pick < 90) return last;
    if (pick < 95 && last != '1) return last + SCORE_W'($urandom_range(1, 1000));
    return SCORE_W'($urandom());
  endfunction

  // Query: hit stored scores exactly, step just beside them, or go anywhere.
  function automatic logic [SCORE_W-1:0] next_query_score();
    logic [SCORE_W-1:0] hit;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (gen_scores.size() == 0 || pick >= 75) return SCORE_W'($urandom());
    hit = gen_scores[$urandom_range(gen_scores.size() - 1)];
    if (pick < 50) return hit;
    if (pick < 63) return hit + 1'b1;
    return hit - 1'b1;
  endfunction

  task automatic build_directed();
    push_query(1'b0, '0);                 // empty board
    push_query(1'b0, '1);
    push_load(1'b1, '1);                  // top score
    push_load(1'b0, '1);                  // duplicate of top
    push_load(1'b0, 31'h4000_0000);
    push_load(1'b0, 31'h4000_0000);
    push_load(1'b0, 31'd1);
    push_load(1'b0, '0);                  // bottom score
    push_query(1'b0, '1);
    push_query(1'b0, 31'h7FFF_FFFE);
    push_query(1'b0, 31'h4000_0000);
    push_query(1'b0, '0);
    push_query(1'b1, 31'h3FFF_FFFF);      // restart flag ignored on a query
    push_load(1'b0, 31'd5);               // rising: sets the sticky error
    push_query(1'b0, '0);
    push_load(1'b1, 31'h5555_5555);       // restart clears board and error
    push_query(1'b0, 31'h2AAA_AAAA);
    push_query(1'b0, 31'h5555_5555);
  endtask

  // Fill the board to the brim, then overflow it and rank against it.
  task automatic build_full_board();
    logic [SCORE_W-1:0] v;
    v = '1;
    push_load(1'b1, v);
    for (int i = 1; i < BOARD_DEPTH + 6; i++) begin
      if (i % 97 == 0) push_query(1'($urandom_range(1)), next_query_score());
      v = v - SCORE_W'($urandom_range(1, 'hFFFFF));
      push_load(1'b0, (i % 211 == 0) ? gen_scores[$] : v);
    end
    push_query(1'b0, '0);                 // rank of the full width
    push_query(1'b0, '1);
    push_query(1'b0, gen_scores[$]);
  endtask

  task automatic build_random();
    int unsigned sent;
    int unsigned seg_len;
    bit          full_done;
    sent      = 0;
    full_done = 0;
    while (sent < RANDOM_BEATS) begin
      if (!full_done && sent >= RANDOM_BEATS / 2) begin
        build_full_board();
        full_done = 1;
      end
      // Each run of beats opens with a restart, then loads and queries mix.
      seg_len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
      push_load(1'b1, ($urandom_range(3) == 0) ? '1 : SCORE_W'($urandom()));
      sent++;
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(99) < 60)
          push_load($urandom_range(49) == 0, next_load_score());
        else
          push_query(1'($urandom_range(1)), next_query_score());
        sent++;
      end
    end
  endtask

  // Sender: advance to the next beat when the current one is taken or none is up.
  int unsigned tx_cycle = 0;
  always @(posedge clk) begin
    score_beat_t nb;
    bit          quiet;
    tx_cycle <= tx_cycle + 1;
    quiet = (tx_cycle >= QUIET_START) && (tx_cycle < QUIET_END);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (score_beats.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
        nb = score_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {nb.score, nb.restart};
        s_tuser  <= nb.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up, a quiet window.
  int unsigned rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
      m_tready <= 1'b0;
    else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_END)
      m_tready <= 1'b1;
    else
      m_tready <= ($urandom_range(99) >= 10);
  end

  // Monitor: check results against the oldest owed rank, then predict new beats.
  int unsigned stall_cycles = 0;
  always @(posedge clk) begin
    rank_result_t want;
    rank_result_t owed;
    bit           moved;
    if (!rst) begin
      moved = 0;
      if (m_tvalid && m_tready) begin
        moved = 1;
        if (rank_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: expected none, got rank %0d err %0d",
                     m_tdata[RANK_W-1:0], m_tdata[RANK_W]);
        end else begin
          want = rank_expect.pop_front();
          if (m_tdata[RANK_W-1:0] !== want.rank || m_tdata[RANK_W] !== want.err ||
              m_tdata[M_TDATA_W-1:RANK_W+1] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"rank mismatch: expected rank %0d err %0d pad 0, ",
                        "got rank %0d err %0d pad %0h"},
                       want.rank, want.err, m_tdata[RANK_W-1:0], m_tdata[RANK_W],
                       m_tdata[M_TDATA_W-1:RANK_W+1]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1;
        beats_taken++;
        if (s_tuser == KIND_QUERY) begin
          owed = '{rank: board_rank(s_tdata[SCORE_W:1]), err: board_err};
          rank_expect.insert(rank_expect.size(), owed);
        end else begin
          board_load(s_tdata[0], s_tdata[SCORE_W:1]);
        end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    beats_total = 0;
    beats_taken = 0;
    mismatches  = 0;
    board_count = 0;
    board_err   = 1'b0;
    build_directed();
    build_random();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Wait for every beat to be taken and every rank to come back, then drain.
    while (beats_taken < beats_total) @(posedge clk);
    while (rank_expect.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && rank_expect.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ dense_rank_lookup_unit.f @@
sv/drl_pkg.sv
sv/drl_ram.sv
sv/dense_rank_lookup_unit.sv
sim/tb_top.sv
